/* rtl/bmde_pkg.sv */
// Package for the binary morphology block: item and result types, configuration
// register indexes, controller states and the controller to datapath command bundle.
// No dependencies.
`timescale 1ns / 1ps

package bmde_pkg;

    localparam int KERNEL_SIZE = 5;
    localparam int PIX_W       = 6;
    localparam int MASK_W      = 25;
    localparam int ANCHOR_W    = 3;
    localparam int DIM_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int KR_W        = $clog2(KERNEL_SIZE + 1);

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_ROW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_COL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERODE_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd5;

    localparam logic [MASK_W-1:0]   RST_KERNEL_MASK = 25'd7399;
    localparam logic [ANCHOR_W-1:0] RST_ANCHOR      = 3'd1;
    localparam logic [DIM_W-1:0]    RST_DIM         = 7'd8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pix_row;
        logic [PIX_W-1:0] pix_col;
        logic             pix_value;
    } bmde_item_t;

    typedef struct packed {
        logic result_pixel;
        logic out_of_range;
    } bmde_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } bmde_state_t;

    typedef struct packed {
        logic            capture;
        logic            rd_en;
        logic [KR_W-1:0] rd_kr;
        logic            finish;
    } bmde_cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_image;
    } bmde_status_t;

endpackage

/* rtl/binary_morphology_dilate_erode.sv */
// Top level of the binary morphology block: dilation or erosion of a stored image.
// Depends on bmde_pkg, bmde_ctrl and bmde_dp.
`timescale 1ns / 1ps

// An item is taken at a rising edge where start is high and busy is low.
// A write item stores pix_value at (pix_row, pix_col) if that pixel lies inside
// the configured image; it gives no result and busy stays low, so writes may
// follow one another in every cycle.
// A query item inside the image reads one image row per cycle from a row-wide
// memory for each of the five kernel rows, accumulates the taps of each row in the
// cycle after its read and then forms the result. busy stays high through the
// scan and finish states, and done, registered from the finish state, pulses once
// busy has dropped; a new item may be taken at the edge that ends the done pulse.
// A query outside the image goes straight to the finish state and answers with
// out_of_range set. The result is valid on result for the single cycle in which
// done is high; the receiver cannot hold it off.
// The user must write configuration through cfg_we, cfg_addr and cfg_data only
// while idle; the block itself does not enforce this. Reset sets the configuration
// registers to their defaults and returns the controller to idle; the image memory
// is not cleared and pixels must be written before they are read.

module binary_morphology_dilate_erode
    import bmde_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bmde_item_t            item,
    output logic                  done,
    output bmde_result_t          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bmde_cmd_t    cmd;
    bmde_status_t status;

    bmde_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    bmde_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .result   (result)
    );

endmodule

/* rtl/bmde_ctrl.sv */
// Controller state machine of the binary morphology block.
// Depends on bmde_pkg; drives the datapath through a bmde_cmd_t bundle.
`timescale 1ns / 1ps

module bmde_ctrl
    import bmde_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  bmde_status_t status,
    output logic         busy,
    output bmde_cmd_t    cmd
);

    bmde_state_t     state_reg, state_next;
    logic [KR_W-1:0] kr_reg, kr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kr_reg    <= kr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kr_next    = kr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                kr_next = '0;
                if (start && status.is_query)
                begin
                    state_next = status.in_image ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                kr_next = kr_reg + 1'b1;
                if (kr_reg == KR_W'(KERNEL_SIZE))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        cmd.capture = (state_reg == ST_IDLE) && start;
        cmd.rd_en   = (state_reg == ST_SCAN) && (kr_reg < KR_W'(KERNEL_SIZE));
        cmd.rd_kr   = kr_reg;
        cmd.finish  = (state_reg == ST_FINISH);
    end

endmodule

/* rtl/bmde_dp.sv */
// Datapath of the binary morphology block: configuration registers, row-wide
// image memory, tap accumulation and the result register. Depends on bmde_pkg.
`timescale 1ns / 1ps

module bmde_dp
    import bmde_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  bmde_item_t            item,
    input  bmde_cmd_t             cmd,
    output bmde_status_t          status,
    output logic                  done,
    output bmde_result_t          result
);

    localparam int AW = $clog2(MAX_DIM);
    localparam int XW = ((AW > PIX_W) ? AW : PIX_W) + 2;

    logic [MASK_W-1:0]   kernel_mask_reg;
    logic [ANCHOR_W-1:0] anchor_row_reg;
    logic [ANCHOR_W-1:0] anchor_col_reg;
    logic                erode_mode_reg;
    logic [XW-1:0]       image_rows_reg;
    logic [XW-1:0]       image_cols_reg;
    logic [XW-1:0]       cfg_dim;

    logic [MAX_DIM-1:0]  mem [MAX_DIM];
    logic [MAX_DIM-1:0]  rd_data_reg;

    logic [AW-1:0]       row_reg;
    logic [AW-1:0]       col_reg;
    logic                oor_reg;
    logic                acc_valid_reg;
    logic [KR_W-1:0]     acc_kr_reg;
    logic                any_reg, any_next;
    logic                all_reg, all_next;
    logic                cov_reg, cov_next;
    logic                done_reg;
    bmde_result_t        result_reg, result_next;

    logic [XW-1:0]       in_row;
    logic [XW-1:0]       in_col;
    logic [XW-1:0]       tr_sum;
    logic [XW-1:0]       tr;
    logic                row_ok;
    logic [KERNEL_SIZE-1:0] mask_row;
    logic [KERNEL_SIZE-1:0] tap_en;
    logic [KERNEL_SIZE-1:0] tap_bit;
    logic [XW-1:0]       tc_sum [KERNEL_SIZE];
    logic [XW-1:0]       tc [KERNEL_SIZE];

    assign cfg_dim = (XW'(cfg_data[DIM_W-1:0]) > XW'(MAX_DIM)) ?
                     XW'(MAX_DIM) : XW'(cfg_data[DIM_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mask_reg <= RST_KERNEL_MASK;
            anchor_row_reg  <= RST_ANCHOR;
            anchor_col_reg  <= RST_ANCHOR;
            erode_mode_reg  <= 1'b0;
            image_rows_reg  <= XW'(RST_DIM);
            image_cols_reg  <= XW'(RST_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_KERNEL_MASK: kernel_mask_reg <= cfg_data[MASK_W-1:0];
                REG_ANCHOR_ROW:  anchor_row_reg  <= cfg_data[ANCHOR_W-1:0];
                REG_ANCHOR_COL:  anchor_col_reg  <= cfg_data[ANCHOR_W-1:0];
                REG_ERODE_MODE:  erode_mode_reg  <= cfg_data[0];
                REG_IMAGE_ROWS:  image_rows_reg  <= cfg_dim;
                REG_IMAGE_COLS:  image_cols_reg  <= cfg_dim;
                default:         ;
            endcase
        end
    end

    assign in_row          = XW'(item.pix_row);
    assign in_col          = XW'(item.pix_col);
    assign status.is_query = (item.req_type == REQ_QUERY);
    assign status.in_image = (in_row < image_rows_reg) && (in_col < image_cols_reg);

    assign tr_sum = XW'(row_reg) + XW'(cmd.rd_kr);
    assign tr     = tr_sum - XW'(anchor_row_reg);
    assign row_ok = (tr_sum >= XW'(anchor_row_reg)) && (tr < image_rows_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture && !status.is_query && status.in_image)
        begin
            mem[in_row[AW-1:0]][in_col[AW-1:0]] <= item.pix_value;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[tr[AW-1:0]];
        end
    end

    always_comb
    begin
        mask_row = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            if (acc_kr_reg == KR_W'(r))
            begin
                mask_row = kernel_mask_reg[r*KERNEL_SIZE +: KERNEL_SIZE];
            end
        end
        for (int c = 0; c < KERNEL_SIZE; c++)
        begin
            tc_sum[c]  = XW'(col_reg) + XW'(c);
            tc[c]      = tc_sum[c] - XW'(anchor_col_reg);
            tap_en[c]  = mask_row[c] && (tc_sum[c] >= XW'(anchor_col_reg))
                         && (tc[c] < image_cols_reg);
            tap_bit[c] = tap_en[c] && rd_data_reg[tc[c][AW-1:0]];
        end
        any_next = any_reg;
        all_next = all_reg;
        cov_next = cov_reg;
        if (acc_valid_reg)
        begin
            any_next = any_reg || (|tap_bit);
            all_next = all_reg && ((tap_bit ^ tap_en) == '0);
            cov_next = cov_reg || (|tap_en);
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.finish)
        begin
            result_next.out_of_range = oor_reg;
            if (oor_reg)
            begin
                result_next.result_pixel = 1'b0;
            end
            else if (erode_mode_reg)
            begin
                result_next.result_pixel = cov_reg && all_reg;
            end
            else
            begin
                result_next.result_pixel = any_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= cmd.rd_en && row_ok;
            done_reg      <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_kr_reg <= cmd.rd_kr;
        result_reg <= result_next;
        if (cmd.capture)
        begin
            row_reg <= in_row[AW-1:0];
            col_reg <= in_col[AW-1:0];
            oor_reg <= !status.in_image;
            any_reg <= 1'b0;
            all_reg <= 1'b1;
            cov_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
            all_reg <= all_next;
            cov_reg <= cov_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
